/* design/hpid_pkg.sv */
// ----------------------------------------------------------------------------
// hpid_pkg: shared types and constants for the heading PID controller
// Request and result payloads, register indexes, fixed-point constants and
// the records passed between the pipeline stages.
// ----------------------------------------------------------------------------
package hpid_pkg;

  localparam int ANGLE_FRAC_BITS = 7;
  localparam int GAIN_FRAC_BITS  = 16;

  localparam int GAIN_W  = 24;
  localparam int LIMIT_W = 16;
  localparam int HDG_W   = 16;
  localparam int ERR_W   = 16;
  localparam int DIFF_W  = 18;
  localparam int DER_W   = 17;
  localparam int INT_W   = 31;
  localparam int ISUM_W  = 32;
  localparam int PP_W    = GAIN_W + ERR_W;
  localparam int PI_W    = GAIN_W + INT_W;
  localparam int PD_W    = GAIN_W + DER_W;
  localparam int ACC_W   = PI_W + 2;
  localparam int SHR_W   = ACC_W - GAIN_FRAC_BITS;
  localparam int IDX_W   = 3;

  localparam logic signed [DIFF_W-1:0] HALF_TURN  = DIFF_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [DIFF_W-1:0] FULL_TURN  = DIFF_W'(360 << ANGLE_FRAC_BITS);
  localparam logic signed [ERR_W-1:0]  RESET_BAND = ERR_W'(15 << ANGLE_FRAC_BITS);
  localparam logic signed [ISUM_W-1:0] INT_LIMIT  =
    ISUM_W'(64'sd7200000 <<< ANGLE_FRAC_BITS);

  localparam logic [IDX_W-1:0] REG_KP_LEFT    = 3'd0;
  localparam logic [IDX_W-1:0] REG_KI_LEFT    = 3'd1;
  localparam logic [IDX_W-1:0] REG_KD_LEFT    = 3'd2;
  localparam logic [IDX_W-1:0] REG_KP_RIGHT   = 3'd3;
  localparam logic [IDX_W-1:0] REG_KI_RIGHT   = 3'd4;
  localparam logic [IDX_W-1:0] REG_KD_RIGHT   = 3'd5;
  localparam logic [IDX_W-1:0] REG_RUDDER_MAX = 3'd6;
  localparam logic [IDX_W-1:0] REG_RUDDER_MIN = 3'd7;

  typedef struct packed {
    logic [HDG_W-1:0] target_heading;
    logic [HDG_W-1:0] measured_heading;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] rudder_command;
    logic               right_gains_used;
  } result_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0]  kp_left;
    logic signed [GAIN_W-1:0]  ki_left;
    logic signed [GAIN_W-1:0]  kd_left;
    logic signed [GAIN_W-1:0]  kp_right;
    logic signed [GAIN_W-1:0]  ki_right;
    logic signed [GAIN_W-1:0]  kd_right;
    logic signed [LIMIT_W-1:0] rudder_max;
    logic signed [LIMIT_W-1:0] rudder_min;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic signed [DER_W-1:0] deriv;
    logic signed [INT_W-1:0] integ;
    logic                    right;
  } err_t;

  typedef struct packed {
    logic signed [PP_W-1:0] pp;
    logic signed [PI_W-1:0] pi;
    logic signed [PD_W-1:0] pd;
    logic                   right;
  } prod_t;

endpackage

/* design/hpid_cfg.sv */
// ----------------------------------------------------------------------------
// hpid_cfg: configuration register file
// Holds the two gain sets and the rudder limits, written by index.
// ----------------------------------------------------------------------------
module hpid_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [hpid_pkg::IDX_W-1:0]  cfg_index,
  input  logic [hpid_pkg::GAIN_W-1:0] cfg_data,
  output hpid_pkg::cfg_t            cfg
);
  import hpid_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_left    <= GAIN_W'(65536);
      cfg.ki_left    <= '0;
      cfg.kd_left    <= GAIN_W'(655);
      cfg.kp_right   <= GAIN_W'(65536);
      cfg.ki_right   <= '0;
      cfg.kd_right   <= GAIN_W'(655);
      cfg.rudder_max <= LIMIT_W'(4480);
      cfg.rudder_min <= -LIMIT_W'(4480);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KP_LEFT:    cfg.kp_left    <= cfg_data;
        REG_KI_LEFT:    cfg.ki_left    <= cfg_data;
        REG_KD_LEFT:    cfg.kd_left    <= cfg_data;
        REG_KP_RIGHT:   cfg.kp_right   <= cfg_data;
        REG_KI_RIGHT:   cfg.ki_right   <= cfg_data;
        REG_KD_RIGHT:   cfg.kd_right   <= cfg_data;
        REG_RUDDER_MAX: cfg.rudder_max <= cfg_data[LIMIT_W-1:0];
        REG_RUDDER_MIN: cfg.rudder_min <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* design/hpid_err.sv */
// ----------------------------------------------------------------------------
// hpid_err: error, derivative and integral stage
// Wraps the heading error, forms the derivative against the stored error and
// updates the clamped integral; the controller state advances per request.
// ----------------------------------------------------------------------------
module hpid_err (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid_in,
  input  hpid_pkg::sample_t sample_in,
  input  logic              ready_out,
  output logic              ready_in,
  output logic              valid,
  output hpid_pkg::err_t    stage
);
  import hpid_pkg::*;

  logic signed [ERR_W-1:0]  previous_error;
  logic signed [INT_W-1:0]  error_integral;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] wrapped;
  logic signed [ISUM_W-1:0] isum;
  logic signed [ISUM_W-1:0] iclamp;
  err_t                     stage_next;
  logic                     take;

  assign ready_in = !valid || ready_out;
  assign take     = valid_in && ready_in;

  always_comb begin
    diff = $signed({2'b00, sample_in.target_heading})
         - $signed({2'b00, sample_in.measured_heading});
    if (diff > HALF_TURN) begin
      wrapped = diff - FULL_TURN;
    end else if (diff < -HALF_TURN) begin
      wrapped = diff + FULL_TURN;
    end else begin
      wrapped = diff;
    end
    stage_next.err   = wrapped[ERR_W-1:0];
    stage_next.deriv = DER_W'(stage_next.err) - DER_W'(previous_error);
    isum = ISUM_W'(error_integral) + ISUM_W'(stage_next.err);
    if (isum > INT_LIMIT) begin
      iclamp = INT_LIMIT;
    end else if (isum < -INT_LIMIT) begin
      iclamp = -INT_LIMIT;
    end else begin
      iclamp = isum;
    end
    if (stage_next.err > RESET_BAND || stage_next.err < -RESET_BAND) begin
      stage_next.integ = '0;
    end else begin
      stage_next.integ = iclamp[INT_W-1:0];
    end
    stage_next.right = !stage_next.err[ERR_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid          <= 1'b0;
      previous_error <= '0;
      error_integral <= '0;
    end else begin
      if (ready_in) begin
        valid <= valid_in;
      end
      if (take) begin
        previous_error <= stage_next.err;
        error_integral <= stage_next.integ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage <= stage_next;
    end
  end

endmodule

/* design/hpid_mul.sv */
// ----------------------------------------------------------------------------
// hpid_mul: gain multiply stage
// Selects the left or right gain set by the error sign and forms the three
// products in parallel.
// ----------------------------------------------------------------------------
module hpid_mul (
  input  logic           clk,
  input  logic           rst,
  input  logic           valid_in,
  input  hpid_pkg::err_t stage_in,
  input  hpid_pkg::cfg_t cfg,
  input  logic           ready_out,
  output logic           ready_in,
  output logic           valid,
  output hpid_pkg::prod_t stage
);
  import hpid_pkg::*;

  logic signed [GAIN_W-1:0] kp;
  logic signed [GAIN_W-1:0] ki;
  logic signed [GAIN_W-1:0] kd;
  prod_t                    stage_next;

  assign ready_in = !valid || ready_out;

  always_comb begin
    kp = stage_in.right ? cfg.kp_right : cfg.kp_left;
    ki = stage_in.right ? cfg.ki_right : cfg.ki_left;
    kd = stage_in.right ? cfg.kd_right : cfg.kd_left;
    stage_next.pp    = PP_W'(kp) * PP_W'(stage_in.err);
    stage_next.pi    = PI_W'(ki) * PI_W'(stage_in.integ);
    stage_next.pd    = PD_W'(kd) * PD_W'(stage_in.deriv);
    stage_next.right = stage_in.right;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_in) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_in && ready_in) begin
      stage <= stage_next;
    end
  end

endmodule

/* design/hpid_sat.sv */
// ----------------------------------------------------------------------------
// hpid_sat: sum, scale and saturate stage
// Adds the products, drops the gain fraction bits and limits the result to
// the rudder range; this is the output register.
// ----------------------------------------------------------------------------
module hpid_sat (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid_in,
  input  hpid_pkg::prod_t stage_in,
  input  hpid_pkg::cfg_t  cfg,
  input  logic            stall,
  output logic            ready_in,
  output logic            valid,
  output hpid_pkg::result_t result
);
  import hpid_pkg::*;

  logic signed [ACC_W-1:0] acc;
  logic signed [SHR_W-1:0] scaled;
  logic signed [SHR_W-1:0] lim_hi;
  logic signed [SHR_W-1:0] lim_lo;
  result_t                 result_next;

  assign ready_in = !valid || !stall;

  always_comb begin
    acc    = ACC_W'(stage_in.pp) + ACC_W'(stage_in.pi) + ACC_W'(stage_in.pd);
    scaled = SHR_W'(acc >>> GAIN_FRAC_BITS);
    lim_hi = SHR_W'(cfg.rudder_max);
    lim_lo = SHR_W'(cfg.rudder_min);
    if (scaled > lim_hi) begin
      result_next.rudder_command = cfg.rudder_max;
    end else if (scaled < lim_lo) begin
      result_next.rudder_command = cfg.rudder_min;
    end else begin
      result_next.rudder_command = scaled[15:0];
    end
    result_next.right_gains_used = stage_in.right;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_in) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_in && ready_in) begin
      result <= result_next;
    end
  end

endmodule

/* design/heading_pid_dual_gain_top.sv */
// ----------------------------------------------------------------------------
// heading_pid_dual_gain_top: heading PID controller with left/right gains
//
//   channel  | signals                              | direction
//   ---------+--------------------------------------+----------
//   sample   | sample_valid, sample_stall, sample   | request in
//   result   | result_valid, result_stall, result   | result out
//   config   | cfg_we, cfg_index, cfg_data          | write in
//
// A request is taken every cycle unless result_stall back-pressure reaches
// the error stage; its result passes the error, multiply and saturate registers.
// The error stage updates its stored error and integral per accepted request.
// Reset clears the stored error and integral and loads the default gains.
// A stalled result holds its stage; bubbles upstream still close up.
// ----------------------------------------------------------------------------
module heading_pid_dual_gain_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_stall,
  input  hpid_pkg::sample_t           sample,
  output logic                        result_valid,
  input  logic                        result_stall,
  output hpid_pkg::result_t           result,
  input  logic                        cfg_we,
  input  logic [hpid_pkg::IDX_W-1:0]  cfg_index,
  input  logic [hpid_pkg::GAIN_W-1:0] cfg_data
);
  import hpid_pkg::*;

  cfg_t  cfg;
  err_t  err_stage;
  prod_t prod_stage;
  logic  err_valid;
  logic  prod_valid;
  logic  err_ready;
  logic  mul_ready;
  logic  sat_ready;

  assign sample_stall = !err_ready;

  hpid_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hpid_err u_err (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (sample_valid),
    .sample_in (sample),
    .ready_out (mul_ready),
    .ready_in  (err_ready),
    .valid     (err_valid),
    .stage     (err_stage)
  );

  hpid_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (err_valid),
    .stage_in  (err_stage),
    .cfg       (cfg),
    .ready_out (sat_ready),
    .ready_in  (mul_ready),
    .valid     (prod_valid),
    .stage     (prod_stage)
  );

  hpid_sat u_sat (
    .clk      (clk),
    .rst      (rst),
    .valid_in (prod_valid),
    .stage_in (prod_stage),
    .cfg      (cfg),
    .stall    (result_stall),
    .ready_in (sat_ready),
    .valid    (result_valid),
    .result   (result)
  );

endmodule
